### design/bdlr_pkg.sv
`timescale 1ns / 1ps

package bdlr_pkg;

   // default timestamp width for internal time arithmetic
   localparam int TIME_BITS_DEFAULT = 32;

   // configuration reset values
   localparam logic [15:0] DEBOUNCE_RESET     = 16'd30;
   localparam logic [15:0] LONG_PRESS_RESET   = 16'd800;
   localparam logic [15:0] REPEAT_FIRST_RESET = 16'd400;
   localparam logic [15:0] REPEAT_RATE_RESET  = 16'd120;

   // configuration register indexes
   typedef enum logic [7:0] {
      CSR_DEBOUNCE     = 8'd0,
      CSR_LONG_PRESS   = 8'd1,
      CSR_REPEAT_FIRST = 8'd2,
      CSR_REPEAT_RATE  = 8'd3
   } csr_index_type;

   // one poll
   typedef struct packed {
      logic        raw_pressed;
      logic [31:0] now_ms;
   } req_type;

   // one result
   typedef struct packed {
      logic        held;
      logic        press_edge;
      logic        release_edge;
      logic        long_pulse;
      logic        repeat_pulse;
      logic [31:0] held_time_ms;
      logic [31:0] last_hold_ms;
   } rsp_type;

   // configuration handed to the core
   typedef struct packed {
      logic [15:0] debounce_ms;
      logic [15:0] long_press_ms;
      logic [15:0] repeat_first_ms;
      logic [15:0] repeat_rate_ms;
   } cfg_type;

endpackage

### design/button_debounce_long_repeat.sv
`timescale 1ns / 1ps

// channel | direction | handshake            | payload
// req     | in        | req_valid, req_stall | req_data  (bdlr_pkg::req_type)
// rsp     | out       | rsp_valid, rsp_stall | rsp_data  (bdlr_pkg::rsp_type)
// csr     | in        | csr_valid, csr_ready | csr_index, csr_wdata
//
// An accepted poll is held in the input register, then its result in the result
// register. One poll per cycle sustained while rsp is not stalled; the state
// loop is a single compare/subtract pass in the core between those two registers.
// Reset (synchronous, active high) empties both stages and restores defaults.
// A stall on rsp holds the result; the input register keeps accepting until full.

module button_debounce_long_repeat #(
   parameter int TIME_BITS = bdlr_pkg::TIME_BITS_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  bdlr_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output bdlr_pkg::rsp_type rsp_data,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [7:0]        csr_index,
   input  logic [15:0]       csr_wdata
);

   logic              in_valid_ff;
   bdlr_pkg::req_type in_data_ff;
   logic              out_valid_ff;
   bdlr_pkg::rsp_type out_data_ff;
   bdlr_pkg::cfg_type cfg_ff;
   bdlr_pkg::rsp_type core_result;
   logic              advance;
   logic              req_take;

   // stage control
   assign advance   = in_valid_ff && (!out_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && !advance;
   assign req_take  = req_valid && !req_stall;
   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;
   assign csr_ready = 1'b1;

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_take) begin
         in_valid_ff <= 1'b1;
      end else if (advance) begin
         in_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_data_ff <= req_data;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_data_ff <= core_result;
      end
   end

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.debounce_ms     <= bdlr_pkg::DEBOUNCE_RESET;
         cfg_ff.long_press_ms   <= bdlr_pkg::LONG_PRESS_RESET;
         cfg_ff.repeat_first_ms <= bdlr_pkg::REPEAT_FIRST_RESET;
         cfg_ff.repeat_rate_ms  <= bdlr_pkg::REPEAT_RATE_RESET;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            bdlr_pkg::CSR_DEBOUNCE:     cfg_ff.debounce_ms     <= csr_wdata;
            bdlr_pkg::CSR_LONG_PRESS:   cfg_ff.long_press_ms   <= csr_wdata;
            bdlr_pkg::CSR_REPEAT_FIRST: cfg_ff.repeat_first_ms <= csr_wdata;
            bdlr_pkg::CSR_REPEAT_RATE:  cfg_ff.repeat_rate_ms  <= csr_wdata;
            default: ;
         endcase
      end
   end

   bdlr_core #(
      .TIME_BITS(TIME_BITS)
   ) u_core (
      .clock (clock),
      .reset (reset),
      .step  (advance),
      .poll  (in_data_ff),
      .cfg   (cfg_ff),
      .result(core_result)
   );

`ifndef SYNTHESIS
   // press and release edges exclude each other
   assert property (@(posedge clock) disable iff (reset)
      out_valid_ff |-> !(out_data_ff.press_edge && out_data_ff.release_edge))
      else $error("press and release on the same poll");

   // every press carries a repeat pulse
   assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && out_data_ff.press_edge) |-> out_data_ff.repeat_pulse)
      else $error("press without repeat pulse");

   // released level reports zero hold time and no long pulse
   assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && !out_data_ff.held) |->
         (out_data_ff.held_time_ms == 32'd0) && !out_data_ff.long_pulse)
      else $error("released poll with hold time or long pulse");

   // input stalls only while the input register holds a poll that cannot move
   assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (in_valid_ff && out_valid_ff && rsp_stall))
      else $error("input stalled without cause");
`endif

endmodule

### design/bdlr_core.sv
`timescale 1ns / 1ps

module bdlr_core #(
   parameter int TIME_BITS = bdlr_pkg::TIME_BITS_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              step,
   input  bdlr_pkg::req_type poll,
   input  bdlr_pkg::cfg_type cfg,
   output bdlr_pkg::rsp_type result
);

   logic                 last_raw_ff,    last_raw_in;
   logic [TIME_BITS-1:0] raw_change_ff,  raw_change_in;
   logic                 stable_ff,      stable_in;
   logic [TIME_BITS-1:0] press_start_ff, press_start_in;
   logic                 long_done_ff,   long_done_in;
   logic [TIME_BITS-1:0] deadline_ff,    deadline_in;
   logic                 armed_ff,       armed_in;
   logic [TIME_BITS-1:0] hold_len_ff,    hold_len_in;

   logic [TIME_BITS-1:0] now_t;
   logic [TIME_BITS-1:0] since_change;
   logic [TIME_BITS-1:0] since_press;
   logic                 level;
   logic                 press;
   logic                 release_now;
   logic                 long_fire;
   logic                 rep_fire;

   // per-poll evaluation
   always_comb begin
      now_t = TIME_BITS'(poll.now_ms);

      // debounce timer restarts on every raw change
      last_raw_in   = poll.raw_pressed;
      raw_change_in = (poll.raw_pressed != last_raw_ff) ? now_t : raw_change_ff;
      since_change  = now_t - raw_change_in;
      level = (since_change >= TIME_BITS'(cfg.debounce_ms)) ? poll.raw_pressed : stable_ff;
      press       = level && !stable_ff;
      release_now = !level && stable_ff;
      stable_in   = level;

      // hold bookkeeping
      press_start_in = press ? now_t : press_start_ff;
      since_press    = now_t - press_start_in;
      hold_len_in    = release_now ? (now_t - press_start_ff) : hold_len_ff;

      // long press fires once per press
      long_fire    = level && !(long_done_ff && !press) &&
                     (since_press >= TIME_BITS'(cfg.long_press_ms));
      long_done_in = long_fire || (long_done_ff && !press);

      // auto-repeat: on press, then at the unsigned deadline
      deadline_in = deadline_ff;
      armed_in    = armed_ff;
      rep_fire    = 1'b0;
      priority if (press) begin
         deadline_in = now_t + TIME_BITS'(cfg.repeat_first_ms);
         armed_in    = 1'b1;
         rep_fire    = 1'b1;
      end else if (level && armed_ff && (now_t >= deadline_ff)) begin
         deadline_in = now_t + TIME_BITS'(cfg.repeat_rate_ms);
         rep_fire    = 1'b1;
      end

      result.held         = level;
      result.press_edge   = press;
      result.release_edge = release_now;
      result.long_pulse   = long_fire;
      result.repeat_pulse = rep_fire;
      result.held_time_ms = level ? 32'(since_press) : 32'd0;
      result.last_hold_ms = 32'(hold_len_in);
   end

   // state update on each transfer through the core
   always_ff @(posedge clock) begin
      if (reset) begin
         last_raw_ff    <= 1'b0;
         raw_change_ff  <= '0;
         stable_ff      <= 1'b0;
         press_start_ff <= '0;
         long_done_ff   <= 1'b0;
         deadline_ff    <= '0;
         armed_ff       <= 1'b0;
         hold_len_ff    <= '0;
      end else if (step) begin
         last_raw_ff    <= last_raw_in;
         raw_change_ff  <= raw_change_in;
         stable_ff      <= stable_in;
         press_start_ff <= press_start_in;
         long_done_ff   <= long_done_in;
         deadline_ff    <= deadline_in;
         armed_ff       <= armed_in;
         hold_len_ff    <= hold_len_in;
      end
   end

endmodule
